>>> hw/rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Types, codes and constants shared by the button, mode and fade controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_MODE   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_NONE   = 2'd3
  } item_kind_e;

  typedef enum logic [1:0] {
    MD_OFF  = 2'd0,
    MD_LOW  = 2'd1,
    MD_MID  = 2'd2,
    MD_HIGH = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_LONG_PRESS = 3'd1,
    CFG_RESET_PRES = 3'd2,
    CFG_SESSION    = 3'd3,
    CFG_FADE_STEP  = 3'd4,
    CFG_LOW_LEVEL  = 3'd5,
    CFG_MID_LEVEL  = 3'd6,
    CFG_HIGH_LEVEL = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;

  localparam logic [5:0]  DebounceRst   = 6'd30;
  localparam logic [12:0] LongPressRst  = 13'd1200;
  localparam logic [12:0] ResetPressRst = 13'd5000;
  localparam logic [21:0] SessionRst    = 22'd900000;
  localparam logic [6:0]  FadeStepRst   = 7'd2;
  localparam logic [8:0]  LowLevelRst   = 9'd102;
  localparam logic [8:0]  MidLevelRst   = 9'd179;
  localparam logic [8:0]  HighLevelRst  = 9'd256;

  localparam logic [3:0]  FadeTicks     = 4'd10;
  localparam logic [12:0] ShortMinTicks = 13'd50;
  localparam logic [5:0]  StableMax     = 6'd63;
  localparam logic [12:0] PressMax      = 13'd8191;
  localparam logic [21:0] SessionMax    = 22'd4194303;
  localparam logic [11:0] RemainMax     = 12'd4095;
  localparam logic [7:0]  DacMid        = 8'd127;

  // x / 1000 = (x >> 3) / 125, done as a reciprocal multiply, exact for 22-bit x
  localparam int unsigned DivPreShift = 3;
  localparam int unsigned RecipShift  = 26;
  localparam logic [19:0] Recip125    = 20'd536871;

  typedef struct packed {
    logic [5:0]  debounce;
    logic [12:0] long_press;
    logic [12:0] reset_press;
    logic [21:0] session;
    logic [6:0]  fade_step;
    logic [8:0]  low_level;
    logic [8:0]  mid_level;
    logic [8:0]  high_level;
  } cfg_t;

  typedef struct packed {
    item_kind_e kind;
    logic       button;
    mode_e      mode_req;
    logic [7:0] sample;
  } q_entry_t;

  typedef struct packed {
    mode_e       mode;
    logic [8:0]  amp;
    logic [7:0]  dac;
    logic        blink;
    logic        rreq;
    logic        active;
    logic [21:0] diff;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/button_mode_fade_controller.sv
// ----------------------------------------------------------------------------
// button_mode_fade_controller
// Button debounce and press timing, mode cycling, session timer, amplitude
// fade and sample scaling; one result per input item.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o   | kind, button_level, mode_request,
//           |                           | sample_in
//   out     | out_valid_o / out_stall_i | mode, amp_scale, dac_value,
//           |                           | remaining_s, blink_event, reset_request
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; each item passes
// the queue and the state update register, then the seconds conversion
// feeds the output register.
// A two-entry queue sits between front and state update; in_stall_o rises
// only when it is full. cfg_ready_o is always high.
// Reset restores the register defaults and the idle state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module button_mode_fade_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic                          button_level_i,
  input  wire logic [1:0]                    mode_request_i,
  input  wire logic [7:0]                    sample_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         mode_o,
  output logic [8:0]                         amp_scale_o,
  output logic [7:0]                         dac_value_o,
  output logic [11:0]                        remaining_s_o,
  output logic                               blink_event_o,
  output logic                               reset_request_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bmf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bmf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bmf_pkg::*;

  logic     q_valid;
  q_entry_t q_head;
  logic     q_pop;
  logic     res_valid;
  res_t     res;
  logic     res_ready;

  assign cfg_ready_o = 1'b1;

  bmf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .button_level_i (button_level_i),
    .mode_request_i (mode_request_i),
    .sample_in_i    (sample_in_i),
    .q_valid_o      (q_valid),
    .q_head_o       (q_head),
    .q_pop_i        (q_pop)
  );

  bmf_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  bmf_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .res_ready_o     (res_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mode_o          (mode_o),
    .amp_scale_o     (amp_scale_o),
    .dac_value_o     (dac_value_o),
    .remaining_s_o   (remaining_s_o),
    .blink_event_o   (blink_event_o),
    .reset_request_o (reset_request_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bmf_front.sv
// ----------------------------------------------------------------------------
// bmf_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic              button_level_i,
  input  wire logic [1:0]        mode_request_i,
  input  wire logic [7:0]        sample_in_i,
  output logic                   q_valid_o,
  output bmf_pkg::q_entry_t      q_head_o,
  input  wire logic              q_pop_i
);
  import bmf_pkg::*;

  q_entry_t   fifo_q [2];
  q_entry_t   entry;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  always_comb begin
    entry.kind     = item_kind_e'(kind_i);
    entry.button   = button_level_i;
    entry.mode_req = mode_e'(mode_request_i);
    entry.sample   = sample_in_i;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_head_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bmf_exec.sv
// ----------------------------------------------------------------------------
// bmf_exec
// Configuration registers and controller state: debounce, press timing, mode,
// session timer, fade, sample scaling; a queued item a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_exec (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [bmf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bmf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          q_valid_i,
  input  wire bmf_pkg::q_entry_t             q_head_i,
  output logic                               q_pop_o,
  output logic                               res_valid_o,
  output bmf_pkg::res_t                      res_o,
  input  wire logic                          res_ready_i
);
  import bmf_pkg::*;

  cfg_t        cfg_q;
  logic        last_raw_q, last_raw_d;
  logic        deb_q, deb_d;
  logic [5:0]  stable_q, stable_d;
  logic [12:0] press_q, press_d;
  logic        long_q, long_d;
  logic        rst_done_q, rst_done_d;
  mode_e       mode_q, mode_d;
  logic [8:0]  target_q, target_d;
  logic [8:0]  level_q, level_d;
  logic [3:0]  div_q, div_d;
  logic [21:0] sess_q, sess_d;
  logic [7:0]  dac_q, dac_d;
  logic        res_valid_q;
  res_t        res_q, res_d;

  logic               step;
  logic               blink, rreq;
  logic               accept;
  mode_e              new_mode;
  logic [9:0]         level_up;
  logic signed [9:0]  centred;
  logic signed [19:0] scaled;
  logic signed [12:0] dac_s;

  assign step        = q_valid_i && (!res_valid_q || res_ready_i);
  assign q_pop_o     = step;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  function automatic logic [8:0] level_of(input mode_e m, input cfg_t c);
    logic [8:0] l;
    unique case (m)
      MD_LOW:  l = c.low_level;
      MD_MID:  l = c.mid_level;
      MD_HIGH: l = c.high_level;
      default: l = 9'd0;
    endcase
    return l;
  endfunction

  always_comb begin
    last_raw_d = last_raw_q;
    deb_d      = deb_q;
    stable_d   = stable_q;
    press_d    = press_q;
    long_d     = long_q;
    rst_done_d = rst_done_q;
    mode_d     = mode_q;
    target_d   = target_q;
    level_d    = level_q;
    div_d      = div_q;
    sess_d     = sess_q;
    dac_d      = dac_q;
    blink      = 1'b0;
    rreq       = 1'b0;
    accept     = 1'b0;
    new_mode   = mode_e'(mode_q + 2'd1);
    level_up   = 10'd0;
    centred    = $signed({2'b00, q_head_i.sample}) - 10'sd127;
    scaled     = centred * $signed({1'b0, level_q});
    dac_s      = $signed({5'd0, DacMid}) + $signed({scaled[19], scaled[19:8]});

    unique case (q_head_i.kind)
      KIND_TICK: begin
        if (!deb_q && press_q != PressMax) begin
          press_d = press_q + 13'd1;
        end
        if (q_head_i.button != last_raw_q) begin
          stable_d = 6'd0;
        end else if (stable_q != StableMax) begin
          stable_d = stable_q + 6'd1;
        end
        last_raw_d = q_head_i.button;
        accept = (stable_d > cfg_q.debounce || stable_d == StableMax) &&
                 (q_head_i.button != deb_q);
        if (accept) begin
          deb_d = q_head_i.button;
          if (!q_head_i.button) begin
            press_d    = 13'd0;
            long_d     = 1'b0;
            rst_done_d = 1'b0;
          end else if (!long_q && !rst_done_q && press_d >= ShortMinTicks &&
                       press_d < cfg_q.long_press) begin
            mode_d   = new_mode;
            target_d = level_of(new_mode, cfg_q);
            if (new_mode != MD_OFF) begin
              sess_d = 22'd0;
            end
          end
        end
        if (!deb_d && !long_d && !rst_done_d && press_d >= cfg_q.long_press &&
            press_d < cfg_q.reset_press) begin
          long_d   = 1'b1;
          mode_d   = MD_OFF;
          target_d = 9'd0;
          blink    = 1'b1;
        end
        if (!deb_d && !rst_done_d && press_d >= cfg_q.reset_press) begin
          rst_done_d = 1'b1;
          rreq       = 1'b1;
        end
        if (mode_d != MD_OFF) begin
          if (sess_d != SessionMax) begin
            sess_d = sess_d + 22'd1;
          end
          if (sess_d >= cfg_q.session) begin
            mode_d   = MD_OFF;
            target_d = 9'd0;
            blink    = 1'b1;
          end
        end
        div_d = div_q + 4'd1;
        if (div_d >= FadeTicks) begin
          div_d = 4'd0;
          if (level_q < target_d) begin
            level_up = {1'b0, level_q} + {3'd0, cfg_q.fade_step};
            level_d  = (level_up > {1'b0, target_d}) ? target_d : level_up[8:0];
          end else if (level_q > target_d) begin
            if ((level_q - target_d) < {2'd0, cfg_q.fade_step}) begin
              level_d = target_d;
            end else begin
              level_d = level_q - {2'd0, cfg_q.fade_step};
            end
          end
        end
      end
      KIND_MODE: begin
        mode_d   = q_head_i.mode_req;
        target_d = level_of(q_head_i.mode_req, cfg_q);
        if (q_head_i.mode_req != MD_OFF) begin
          sess_d = 22'd0;
        end
      end
      KIND_SAMPLE: begin
        if (dac_s < 13'sd0) begin
          dac_d = 8'd0;
        end else if (dac_s > 13'sd255) begin
          dac_d = 8'd255;
        end else begin
          dac_d = dac_s[7:0];
        end
      end
      default: begin
      end
    endcase

    res_d.mode   = mode_d;
    res_d.amp    = level_d;
    res_d.dac    = dac_d;
    res_d.blink  = blink;
    res_d.rreq   = rreq;
    res_d.active = (mode_d != MD_OFF) && (sess_d < cfg_q.session);
    res_d.diff   = cfg_q.session - sess_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce    <= DebounceRst;
      cfg_q.long_press  <= LongPressRst;
      cfg_q.reset_press <= ResetPressRst;
      cfg_q.session     <= SessionRst;
      cfg_q.fade_step   <= FadeStepRst;
      cfg_q.low_level   <= LowLevelRst;
      cfg_q.mid_level   <= MidLevelRst;
      cfg_q.high_level  <= HighLevelRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE:   cfg_q.debounce    <= cfg_data_i[5:0];
        CFG_LONG_PRESS: cfg_q.long_press  <= cfg_data_i[12:0];
        CFG_RESET_PRES: cfg_q.reset_press <= cfg_data_i[12:0];
        CFG_SESSION:    cfg_q.session     <= cfg_data_i;
        CFG_FADE_STEP:  cfg_q.fade_step   <= cfg_data_i[6:0];
        CFG_LOW_LEVEL:  cfg_q.low_level   <= cfg_data_i[8:0];
        CFG_MID_LEVEL:  cfg_q.mid_level   <= cfg_data_i[8:0];
        CFG_HIGH_LEVEL: cfg_q.high_level  <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b1;
      deb_q      <= 1'b1;
      stable_q   <= 6'd0;
      press_q    <= 13'd0;
      long_q     <= 1'b0;
      rst_done_q <= 1'b0;
      mode_q     <= MD_OFF;
      target_q   <= 9'd0;
      level_q    <= 9'd0;
      div_q      <= 4'd0;
      sess_q     <= 22'd0;
      dac_q      <= DacMid;
    end else if (step) begin
      last_raw_q <= last_raw_d;
      deb_q      <= deb_d;
      stable_q   <= stable_d;
      press_q    <= press_d;
      long_q     <= long_d;
      rst_done_q <= rst_done_d;
      mode_q     <= mode_d;
      target_q   <= target_d;
      level_q    <= level_d;
      div_q      <= div_d;
      sess_q     <= sess_d;
      dac_q      <= dac_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || res_ready_i) begin
      res_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bmf_out.sv
// ----------------------------------------------------------------------------
// bmf_out
// Output register: converts the session ticks left into whole seconds and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  input  wire bmf_pkg::res_t res_i,
  output logic               res_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         mode_o,
  output logic [8:0]         amp_scale_o,
  output logic [7:0]         dac_value_o,
  output logic [11:0]        remaining_s_o,
  output logic               blink_event_o,
  output logic               reset_request_o
);
  import bmf_pkg::*;

  logic        out_valid_q;
  logic [1:0]  mode_q;
  logic [8:0]  amp_q;
  logic [7:0]  dac_q;
  logic [11:0] remain_q, remain_d;
  logic        blink_q;
  logic        rreq_q;
  logic [38:0] prod;
  logic [12:0] secs;
  logic        load;

  assign res_ready_o = !out_valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    prod = {20'd0, res_i.diff[21:DivPreShift]} * {19'd0, Recip125};
    secs = prod[RecipShift +: 13];
    if (!res_i.active) begin
      remain_d = 12'd0;
    end else if (secs > {1'b0, RemainMax}) begin
      remain_d = RemainMax;
    end else begin
      remain_d = secs[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q   <= res_i.mode;
      amp_q    <= res_i.amp;
      dac_q    <= res_i.dac;
      remain_q <= remain_d;
      blink_q  <= res_i.blink;
      rreq_q   <= res_i.rreq;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = mode_q;
  assign amp_scale_o     = amp_q;
  assign dac_value_o     = dac_q;
  assign remaining_s_o   = remain_q;
  assign blink_event_o   = blink_q;
  assign reset_request_o = rreq_q;

endmodule

`default_nettype wire

>>> hw/rtl/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks on the controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic                          button_level_i,
  input  wire logic [1:0]                    mode_request_i,
  input  wire logic [7:0]                    sample_in_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire logic [1:0]                    mode_o,
  input  wire logic [8:0]                    amp_scale_o,
  input  wire logic [7:0]                    dac_value_o,
  input  wire logic [11:0]                   remaining_s_o,
  input  wire logic                          blink_event_o,
  input  wire logic                          reset_request_o,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_o,
  input  wire logic [bmf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bmf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bmf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o) &&
      $stable(amp_scale_o) && $stable(dac_value_o) && $stable(remaining_s_o))
    else $error("stalled result changed");

  a_off_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == MD_OFF) |-> (remaining_s_o == 12'd0))
    else $error("seconds left reported while off");

  a_blink_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blink_event_o |-> (mode_o == MD_OFF))
    else $error("blink without forced off");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind button_mode_fade_controller bmf_checker u_bmf_checker (.*);

`default_nettype wire
